### hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

    // default build sizes
    localparam int POOL_DEPTH_DEF = 256;
    localparam int ADDR_BITS_DEF  = 32;

    // fixed field widths
    localparam int BLOCK_W   = 16;
    localparam int ENTRIES_W = 9;
    localparam int USED_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY      = 2'd1,
        STAT_MISALIGNED = 2'd2,
        STAT_RANGE      = 2'd3
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE    = 2'd0,
        CFG_BLOCK_BYTES  = 2'd1,
        CFG_POOL_ENTRIES = 2'd2
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_POP  = 2'd1,
        S_DIV  = 2'd2,
        S_OUT  = 2'd3
    } t_state;

endpackage

### hw/rtl/fbpa_div.sv
module fbpa_div #(
    parameter int DIV_W = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DIV_W-1:0]             i_dividend,
    input  logic [fbpa_pkg::BLOCK_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [DIV_W-1:0]             o_quotient,
    output logic [fbpa_pkg::BLOCK_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]             r_quo;
    logic [fbpa_pkg::BLOCK_W-1:0] r_rem;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_done;

    logic [fbpa_pkg::BLOCK_W:0] rem_sh;
    logic [fbpa_pkg::BLOCK_W:0] rem_sub;
    logic                       fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        fits    = rem_sh >= {1'b0, i_divisor};
        rem_sub = rem_sh - {1'b0, i_divisor};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // quotient shifts into the dividend register as it drains
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? rem_sub[fbpa_pkg::BLOCK_W-1:0] : rem_sh[fbpa_pkg::BLOCK_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### hw/rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator. Hands out blocks of block_bytes bytes from a pool that
// starts at pool_base, most recently freed block first, then never-used blocks in ascending
// order; reinitialise empties the free list. The free list lives in a link memory with a
// registered read, the head, fresh index and use count in registers. One request is
// worked on at a time: allocate does a link read, then an address multiply and add;
// reinitialise and the unused mode go straight to the result; free sends the address
// offset through a bit-serial divider by block_bytes, one quotient bit per cycle. A new
// request is taken as soon as the previous one has moved to the output register, even if
// that result is still waiting to be taken. Blocks whose links were never written read
// back undefined, so only the free list as built since reset is meaningful.
module fixed_block_pool_allocator #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF,
    parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_BITS-1:0]           i_cfg_data,
    // requests
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [fbpa_pkg::MODE_W-1:0]    i_mode,
    input  logic [ADDR_BITS-1:0]           i_block_address,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]  o_status,
    output logic [ADDR_BITS-1:0]           o_granted_address,
    output logic [fbpa_pkg::USED_W-1:0]    o_blocks_in_use
);

    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int HEAD_W = IDX_W + 1;
    localparam int NUM_W  = (HEAD_W > fbpa_pkg::ENTRIES_W) ? HEAD_W : fbpa_pkg::ENTRIES_W;
    localparam int PROD_W = (IDX_W + fbpa_pkg::BLOCK_W > ADDR_BITS)
                          ? IDX_W + fbpa_pkg::BLOCK_W : ADDR_BITS;
    localparam logic [HEAD_W-1:0] LIST_END = HEAD_W'(POOL_DEPTH);
    localparam logic [NUM_W-1:0]  DEPTH_N  = NUM_W'(POOL_DEPTH);

    // configuration registers
    logic [ADDR_BITS-1:0]           r_pool_base;
    logic [fbpa_pkg::BLOCK_W-1:0]   r_block_bytes;
    logic [fbpa_pkg::ENTRIES_W-1:0] r_pool_entries;

    // control state
    fbpa_pkg::t_state               r_state, n_state;
    logic [HEAD_W-1:0]              r_freed_head, n_freed_head;
    logic [HEAD_W-1:0]              r_fresh_index, n_fresh_index;
    logic [fbpa_pkg::USED_W-1:0]    r_used, n_used;

    // pending result
    logic [fbpa_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic [ADDR_BITS-1:0]           r_res_granted, n_res_granted;
    logic [fbpa_pkg::USED_W-1:0]    r_res_used, n_res_used;

    // output register
    logic                           r_out_valid, n_out_valid;
    logic [fbpa_pkg::STATUS_W-1:0]  r_out_status;
    logic [ADDR_BITS-1:0]           r_out_granted;
    logic [fbpa_pkg::USED_W-1:0]    r_out_used;

    // link memory
    logic [HEAD_W-1:0]              r_link [POOL_DEPTH];
    logic [HEAD_W-1:0]              r_link_rd;
    logic                           link_re;
    logic                           link_we;
    logic [IDX_W-1:0]               link_waddr;
    logic [HEAD_W-1:0]              link_wdata;

    // divider hookup
    logic                           div_start;
    logic                           div_done;
    logic [ADDR_BITS-1:0]           div_quo;
    logic [fbpa_pkg::BLOCK_W-1:0]   div_rem;

    // helpers
    logic [NUM_W-1:0]               entries_now;
    logic [ADDR_BITS-1:0]           offset;
    logic                           in_take;
    logic                           out_free;
    logic                           have_freed;
    logic [HEAD_W-1:0]              link_next;
    logic [IDX_W-1:0]               alloc_idx;
    logic [PROD_W-1:0]              alloc_prod;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == fbpa_pkg::S_IDLE);
    assign in_take     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // pool size clamped to the built depth
    assign entries_now = (NUM_W'(r_pool_entries) > DEPTH_N) ? DEPTH_N : NUM_W'(r_pool_entries);
    assign offset      = i_block_address - r_pool_base;

    // allocate path: freed stack first, then fresh blocks
    assign have_freed  = r_freed_head < LIST_END;
    assign link_next   = (r_link_rd < LIST_END) ? r_link_rd : LIST_END;
    assign alloc_idx   = have_freed ? r_freed_head[IDX_W-1:0] : r_fresh_index[IDX_W-1:0];
    assign alloc_prod  = PROD_W'(alloc_idx) * PROD_W'(r_block_bytes);
    assign link_re     = (r_state == fbpa_pkg::S_IDLE) && have_freed;

    fbpa_div #(
        .DIV_W (ADDR_BITS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (offset),
        .i_divisor   (r_block_bytes),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= '0;
            r_block_bytes  <= fbpa_pkg::BLOCK_W'(64);
            r_pool_entries <= fbpa_pkg::ENTRIES_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (fbpa_pkg::t_cfg_idx'(i_cfg_index))
                fbpa_pkg::CFG_POOL_BASE:    r_pool_base    <= i_cfg_data;
                fbpa_pkg::CFG_BLOCK_BYTES:  r_block_bytes  <= i_cfg_data[fbpa_pkg::BLOCK_W-1:0];
                fbpa_pkg::CFG_POOL_ENTRIES: r_pool_entries <= i_cfg_data[fbpa_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: next state, state updates and result
    always_comb begin
        n_state       = r_state;
        n_freed_head  = r_freed_head;
        n_fresh_index = r_fresh_index;
        n_used        = r_used;
        n_res_status  = r_res_status;
        n_res_granted = r_res_granted;
        n_res_used    = r_res_used;
        n_out_valid   = r_out_valid && !i_out_ready;
        div_start     = 1'b0;
        link_we       = 1'b0;
        link_waddr    = '0;
        link_wdata    = r_freed_head;

        case (r_state)
            fbpa_pkg::S_IDLE: begin
                if (in_take) begin
                    n_res_status  = fbpa_pkg::STAT_OK;
                    n_res_granted = '0;
                    n_res_used    = r_used;
                    case (fbpa_pkg::t_mode'(i_mode))
                        fbpa_pkg::MODE_ALLOC: begin
                            n_state = fbpa_pkg::S_POP;
                        end
                        fbpa_pkg::MODE_FREE: begin
                            if (r_block_bytes == '0) begin
                                n_res_status = fbpa_pkg::STAT_MISALIGNED;
                                n_state      = fbpa_pkg::S_OUT;
                            end else begin
                                div_start = 1'b1;
                                n_state   = fbpa_pkg::S_DIV;
                            end
                        end
                        fbpa_pkg::MODE_INIT: begin
                            n_freed_head  = LIST_END;
                            n_fresh_index = '0;
                            n_used        = '0;
                            n_res_used    = '0;
                            n_state       = fbpa_pkg::S_OUT;
                        end
                        default: begin
                            n_state = fbpa_pkg::S_OUT;
                        end
                    endcase
                end
            end

            fbpa_pkg::S_POP: begin
                // link of the head is in r_link_rd now
                if (have_freed || (NUM_W'(r_fresh_index) < entries_now)) begin
                    if (have_freed) begin
                        n_freed_head = link_next;
                    end else begin
                        n_fresh_index = r_fresh_index + 1'b1;
                    end
                    if (r_used != '1) begin
                        n_used = r_used + 1'b1;
                    end
                    n_res_granted = r_pool_base + alloc_prod[ADDR_BITS-1:0];
                end else begin
                    n_res_status = fbpa_pkg::STAT_EMPTY;
                end
                n_res_used = n_used;
                n_state    = fbpa_pkg::S_OUT;
            end

            fbpa_pkg::S_DIV: begin
                if (div_done) begin
                    if (div_rem != '0) begin
                        n_res_status = fbpa_pkg::STAT_MISALIGNED;
                    end else if (div_quo >= ADDR_BITS'(entries_now)) begin
                        n_res_status = fbpa_pkg::STAT_RANGE;
                    end else begin
                        // push the freed index on the stack
                        link_we      = 1'b1;
                        link_waddr   = div_quo[IDX_W-1:0];
                        n_freed_head = {1'b0, div_quo[IDX_W-1:0]};
                        if (r_used != '0) begin
                            n_used = r_used - 1'b1;
                        end
                    end
                    n_res_used = n_used;
                    n_state    = fbpa_pkg::S_OUT;
                end
            end

            fbpa_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = fbpa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = fbpa_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fbpa_pkg::S_IDLE;
            r_freed_head  <= LIST_END;
            r_fresh_index <= '0;
            r_used        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_freed_head  <= n_freed_head;
            r_fresh_index <= n_fresh_index;
            r_used        <= n_used;
            r_out_valid   <= n_out_valid;
        end
    end

    // result and output payload
    always_ff @(posedge i_clk) begin
        r_res_status  <= n_res_status;
        r_res_granted <= n_res_granted;
        r_res_used    <= n_res_used;
        if ((r_state == fbpa_pkg::S_OUT) && out_free) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_used    <= r_res_used;
        end
    end

    // link memory, registered read
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            r_link_rd <= r_link[r_freed_head[IDX_W-1:0]];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_granted;
    assign o_blocks_in_use   = r_out_used;

endmodule
